>>> hdl/timer_prescaler_compare_selector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer prescaler compare selector
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_COMPARE_SELECTOR_MACROS_SVH
`define TIMER_PRESCALER_COMPARE_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define TPCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tpcs: assertion failed");
// cons must hold in the cycle after ante
`define TPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpcs: assertion failed");
`else
`define TPCS_ASSERT(lbl, clk, rst, prop)
`define TPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// Types, constants and prescaler tables shared by the selector modules.
// ----------------------------------------------------------------------------
package tpcs_pkg;

   localparam int NUM_CELLS = 7;          // one cell per prescaler position
   localparam int IDX_W     = 3;
   localparam int D_W       = 32;         // desired period
   localparam int CNT_W     = 17;         // count up to 65536
   localparam int ERR_W     = 10;         // error of a fitting count < 1024
   localparam int PER_W     = 27;         // count << shift
   localparam int CMP_W     = 16;

   localparam logic [1:0] TIMER_ONE = 2'd1;
   localparam logic [1:0] TIMER_TWO = 2'd2;

   localparam logic [D_W-1:0] MIN_PERIOD = 32'd16;

   localparam logic [CNT_W-1:0] T1_SIZE = 17'd65536;
   localparam logic [CNT_W-1:0] T2_SIZE = 17'd256;

   localparam logic [CMP_W-1:0] T1_FULL_CMP = CMP_W'(2 * (65536 - 1) / 3);
   localparam logic [CMP_W-1:0] T2_FULL_CMP = CMP_W'(2 * (256 - 1) / 3);

   localparam logic [7:0] T1_CTC_B = 8'h08;
   localparam logic [7:0] T2_CTC_A = 8'h02;

   localparam logic [1:0] SLOTS_NORMAL = 2'd3;
   localparam logic [1:0] SLOTS_CTC    = 2'd2;

   // shift per prescaler position, position 7 first
   localparam logic [7:0][3:0] T1_SHIFT = {4'd0, 4'd0, 4'd0, 4'd10, 4'd8, 4'd6, 4'd3, 4'd0};
   localparam logic [7:0][3:0] T2_SHIFT = {4'd0, 4'd10, 4'd8, 4'd7, 4'd6, 4'd5, 4'd3, 4'd0};
   localparam logic [7:0]      T1_USED  = 8'b0001_1111;
   localparam logic [7:0]      T2_USED  = 8'b0111_1111;

   typedef struct packed {
      logic             valid;
      logic [1:0]       timer_select;
      logic [D_W-1:0]   desired;
      logic             found;
      logic [ERR_W-1:0] best_err;
      logic [CNT_W-1:0] win_count;
      logic [IDX_W-1:0] best_idx;
   } stage_type;

   function automatic logic [3:0] cell_shift(input logic [1:0] sel,
                                             input logic [IDX_W-1:0] idx);
      logic [3:0] s;
      s = (sel == TIMER_ONE) ? T1_SHIFT[idx] : T2_SHIFT[idx];
      return s;
   endfunction

   function automatic logic cell_used(input logic [1:0] sel,
                                      input logic [IDX_W-1:0] idx);
      logic u;
      unique case (sel)
         TIMER_ONE: u = T1_USED[idx];
         TIMER_TWO: u = T2_USED[idx];
         default:   u = 1'b0;
      endcase
      return u;
   endfunction

endpackage

>>> hdl/tpcs_if.sv
// ----------------------------------------------------------------------------
// tpcs channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tpcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  timer_select;
   logic [31:0] desired_period_cycles;

   modport source (output valid, output timer_select, output desired_period_cycles,
                   input ready);
   modport sink   (input valid, input timer_select, input desired_period_cycles,
                   output ready);
endinterface

interface tpcs_rsp_if;
   logic        valid;
   logic        ready;
   logic        error_flag;
   logic [7:0]  control_a;
   logic [7:0]  control_b;
   logic [15:0] match_a;
   logic [15:0] match_b;
   logic [1:0]  handler_slots;
   logic [26:0] actual_period_cycles;

   modport source (output valid, output error_flag, output control_a, output control_b,
                   output match_a, output match_b, output handler_slots,
                   output actual_period_cycles, input ready);
   modport sink   (input valid, input error_flag, input control_a, input control_b,
                   input match_a, input match_b, input handler_slots,
                   input actual_period_cycles, output ready);
endinterface

>>> hdl/tpcs_cell.sv
// ----------------------------------------------------------------------------
// tpcs_cell
// One prescaler position: tries ceiling then floor count, keeps the better.
// ----------------------------------------------------------------------------
module tpcs_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  tpcs_pkg::stage_type stage_in,
   input  logic                en_down,
   output logic                en_up,
   output tpcs_pkg::stage_type stage_out
);

   localparam logic [tpcs_pkg::IDX_W-1:0] IDX_CODE = tpcs_pkg::IDX_W'(IDX);

   tpcs_pkg::stage_type stage_ff, stage_in_upd;

   logic [3:0]                 shift;
   logic                       go;
   logic [tpcs_pkg::D_W:0]     mask;
   logic [tpcs_pkg::D_W:0]     ceil_cnt, floor_cnt, size;
   logic [tpcs_pkg::PER_W-1:0] per_c, per_f;
   logic [tpcs_pkg::ERR_W-1:0] err_c, err_f;
   logic                       fit_c, fit_f;

   function automatic logic [tpcs_pkg::ERR_W-1:0] abs_err(
      input logic [tpcs_pkg::PER_W-1:0] per, input logic [tpcs_pkg::D_W-1:0] d);
      logic [tpcs_pkg::D_W:0] p33, d33, e;
      p33 = (tpcs_pkg::D_W+1)'(per);
      d33 = {1'b0, d};
      e   = (p33 >= d33) ? (p33 - d33) : (d33 - p33);
      return e[tpcs_pkg::ERR_W-1:0];   // a fitting count misses by less than p
   endfunction

   always_comb begin
      shift = tpcs_pkg::cell_shift(stage_in.timer_select, IDX_CODE);
      go    = tpcs_pkg::cell_used(stage_in.timer_select, IDX_CODE)
              && (stage_in.desired >= tpcs_pkg::MIN_PERIOD);
      mask      = ((tpcs_pkg::D_W+1)'(1) << shift) - (tpcs_pkg::D_W+1)'(1);
      ceil_cnt  = ({1'b0, stage_in.desired} + mask) >> shift;
      floor_cnt = {1'b0, stage_in.desired} >> shift;
      size      = (tpcs_pkg::D_W+1)'((stage_in.timer_select == tpcs_pkg::TIMER_ONE)
                                     ? tpcs_pkg::T1_SIZE : tpcs_pkg::T2_SIZE);
      fit_c = go && (ceil_cnt != '0) && (ceil_cnt <= size);
      fit_f = go && (floor_cnt != '0) && (floor_cnt <= size);
      per_c = tpcs_pkg::PER_W'(ceil_cnt[tpcs_pkg::CNT_W-1:0]) << shift;
      per_f = tpcs_pkg::PER_W'(floor_cnt[tpcs_pkg::CNT_W-1:0]) << shift;
      err_c = abs_err(per_c, stage_in.desired);
      err_f = abs_err(per_f, stage_in.desired);

      stage_in_upd = stage_in;
      // ceiling first, then floor; strict compare keeps the earlier on a tie
      if (fit_c && (!stage_in_upd.found || err_c < stage_in_upd.best_err)) begin
         stage_in_upd.found     = 1'b1;
         stage_in_upd.best_err  = err_c;
         stage_in_upd.win_count = ceil_cnt[tpcs_pkg::CNT_W-1:0];
         stage_in_upd.best_idx  = IDX_CODE;
      end
      if (fit_f && (!stage_in_upd.found || err_f < stage_in_upd.best_err)) begin
         stage_in_upd.found     = 1'b1;
         stage_in_upd.best_err  = err_f;
         stage_in_upd.win_count = floor_cnt[tpcs_pkg::CNT_W-1:0];
         stage_in_upd.best_idx  = IDX_CODE;
      end
   end

   // load when empty or when the next stage moves on
   assign en_up = !stage_ff.valid || en_down;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en_up) begin
         stage_ff <= stage_in_upd;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> hdl/tpcs_out.sv
// ----------------------------------------------------------------------------
// tpcs_out
// Turns the winning count into control bytes and compare values; output reg.
// ----------------------------------------------------------------------------
module tpcs_out (
   input  logic                clock,
   input  logic                reset,
   input  tpcs_pkg::stage_type stage_in,
   output logic                en_up,
   tpcs_rsp_if.source          rsp
);

   logic                       valid_ff;
   logic                       error_ff, error_in;
   logic [7:0]                 ctrl_a_ff, ctrl_a_in, ctrl_b_ff, ctrl_b_in;
   logic [tpcs_pkg::CMP_W-1:0] cmp_a_ff, cmp_a_in, cmp_b_ff, cmp_b_in;
   logic [1:0]                 slots_ff, slots_in;
   logic [tpcs_pkg::PER_W-1:0] per_ff, per_in;

   logic                       is_t1, full;
   logic [3:0]                 shift;

   always_comb begin
      is_t1 = (stage_in.timer_select == tpcs_pkg::TIMER_ONE);
      full  = stage_in.win_count == (is_t1 ? tpcs_pkg::T1_SIZE : tpcs_pkg::T2_SIZE);
      shift = tpcs_pkg::cell_shift(stage_in.timer_select, stage_in.best_idx);

      error_in  = !stage_in.found;
      ctrl_a_in = 8'd0;
      ctrl_b_in = 8'd0;
      cmp_a_in  = '0;
      slots_in  = 2'd0;
      per_in    = '0;
      if (stage_in.found) begin
         ctrl_b_in = 8'(stage_in.best_idx) + 8'd1;   // clock select code
         per_in    = tpcs_pkg::PER_W'(stage_in.win_count) << shift;
         if (full) begin
            cmp_a_in = is_t1 ? tpcs_pkg::T1_FULL_CMP : tpcs_pkg::T2_FULL_CMP;
            slots_in = tpcs_pkg::SLOTS_NORMAL;
         end else begin
            cmp_a_in = stage_in.win_count[tpcs_pkg::CMP_W-1:0] - tpcs_pkg::CMP_W'(1);
            slots_in = tpcs_pkg::SLOTS_CTC;
            if (is_t1) begin
               ctrl_b_in = ctrl_b_in | tpcs_pkg::T1_CTC_B;
            end else begin
               ctrl_a_in = tpcs_pkg::T2_CTC_A;
            end
         end
      end
      cmp_b_in = cmp_a_in >> 1;
   end

   assign en_up = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en_up) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_up) begin
         error_ff  <= error_in;
         ctrl_a_ff <= ctrl_a_in;
         ctrl_b_ff <= ctrl_b_in;
         cmp_a_ff  <= cmp_a_in;
         cmp_b_ff  <= cmp_b_in;
         slots_ff  <= slots_in;
         per_ff    <= per_in;
      end
   end

   assign rsp.valid                = valid_ff;
   assign rsp.error_flag           = error_ff;
   assign rsp.control_a            = ctrl_a_ff;
   assign rsp.control_b            = ctrl_b_ff;
   assign rsp.match_a              = cmp_a_ff;
   assign rsp.match_b              = cmp_b_ff;
   assign rsp.handler_slots        = slots_ff;
   assign rsp.actual_period_cycles = per_ff;

endmodule

>>> hdl/timer_prescaler_compare_selector.sv
// ----------------------------------------------------------------------------
// timer_prescaler_compare_selector
// Picks prescaler, count and compare values for a wanted timer period.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+----------------------------------------
//  req_chan  | in  | valid / ready    | timer_select, desired_period_cycles
//  rsp_chan  | out | valid / ready    | error_flag, control_a/b, match_a/b,
//            |     |                  | handler_slots, actual_period_cycles
//
//  One item per cycle sustained while the result side is ready; each item passes
//  one register per prescaler cell (7) and then the output register.
//  Each cell owns one stage register and loads whenever it is empty or its
//  neighbor moves on, so a stalled result only backs up the chain once
//  every empty slot between input and output has filled.
//  Synchronous active-high reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "timer_prescaler_compare_selector_macros.svh"

module timer_prescaler_compare_selector (
   input  logic     clock,
   input  logic     reset,
   tpcs_req_if.sink   req_chan,
   tpcs_rsp_if.source rsp_chan
);

   localparam int N = tpcs_pkg::NUM_CELLS;

   // stage[k] feeds cell k; stage[N] is the last cell's register
   tpcs_pkg::stage_type stage [N+1];
   logic [N:0]          en;
   logic                rsp_fields_zero;

   // fresh item enters with no candidate yet
   always_comb begin
      stage[0]              = '0;
      stage[0].valid        = req_chan.valid;
      stage[0].timer_select = req_chan.timer_select;
      stage[0].desired      = req_chan.desired_period_cycles;
   end

   assign req_chan.ready = en[0];

   // one cell per prescaler position, ascending
   for (genvar k = 0; k < N; k++) begin : g_cell
      tpcs_cell #(
         .IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[k]),
         .en_down   (en[k+1]),
         .en_up     (en[k]),
         .stage_out (stage[k+1])
      );
   end

   // result formatting and output register
   tpcs_out u_out (
      .clock    (clock),
      .reset    (reset),
      .stage_in (stage[N]),
      .en_up    (en[N]),
      .rsp      (rsp_chan)
   );

   assign rsp_fields_zero = (rsp_chan.control_a == 8'd0) && (rsp_chan.control_b == 8'd0)
                            && (rsp_chan.match_a == 16'd0) && (rsp_chan.handler_slots == 2'd0)
                            && (rsp_chan.actual_period_cycles == 27'd0);

   // with nothing waiting at the output the whole chain can move
   `TPCS_ASSERT(a_ready_when_out_empty, clock, reset, !rsp_chan.valid |-> req_chan.ready)
   // error items carry all-zero fields
   `TPCS_ASSERT(a_error_fields_zero, clock, reset, (rsp_chan.valid && rsp_chan.error_flag) |-> rsp_fields_zero)
   // compare B always tracks half of compare A
   `TPCS_ASSERT(a_cmp_b_half, clock, reset, rsp_chan.valid |-> (rsp_chan.match_b == (rsp_chan.match_a >> 1)))
   // a held last stage is never dropped
   `TPCS_ASSERT_NEXT(a_last_stage_held, clock, reset, stage[N].valid && !en[N], stage[N].valid)

endmodule

>>> tb/sv/timer_prescaler_compare_selector_tb.sv
// ----------------------------------------------------------------------------
// timer_prescaler_compare_selector_tb
// Drives timer/period requests through the selector and checks every result
// against a hand-written or locally searched expectation: a short table of edge
// cases first, then random requests under shifting back-pressure and a long result stall.
// ----------------------------------------------------------------------------
module timer_prescaler_compare_selector_tb;

   // timer codes the block must refuse
   localparam logic [1:0] TIMER_NONE = 2'd0;
   localparam logic [1:0] TIMER_RSVD = 2'd3;

   localparam int RANDOM_ITEMS  = 1425;
   localparam int DRAIN_CYCLES  = 16;      // pipeline is 8 deep
   localparam int HOLD_OFF_LEN  = 150;     // long result stall, in cycles
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic        error_flag;
      logic [7:0]  control_a;
      logic [7:0]  control_b;
      logic [15:0] match_a;
      logic [15:0] match_b;
      logic [1:0]  handler_slots;
      logic [26:0] actual_period_cycles;
   } timer_setting_type;

   // refused request: error flag alone
   localparam timer_setting_type REFUSED = {1'b1, 77'd0};

   typedef struct {
      logic [1:0]        timer_select;
      logic [31:0]       period;
      bit                typed;       // result written in by hand
      timer_setting_type result;
   } stim_row_type;

   logic clock;
   logic reset;

   tpcs_req_if req_chan ();
   tpcs_rsp_if rsp_chan ();

   timer_prescaler_compare_selector dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   timer_setting_type pending_settings [$];
   stim_row_type      directed_rows [$];
   int                mismatch_count = 0;
   int                result_count   = 0;
   int                req_idle_pct   = 10;
   int                rsp_idle_pct   = 71;
   bit                hold_off_pending = 1'b0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // shift of prescaler position idx; timer 1 has five, timer 2 seven
   function automatic int prescale_shift(input logic [1:0] sel, input int idx);
      int sh;
      sh = 0;
      if (sel == tpcs_pkg::TIMER_ONE) begin
         case (idx)
            1: sh = 3;
            2: sh = 6;
            3: sh = 8;
            4: sh = 10;
            default: sh = 0;
         endcase
      end else begin
         case (idx)
            1: sh = 3;
            2: sh = 5;
            3: sh = 6;
            4: sh = 7;
            5: sh = 8;
            6: sh = 10;
            default: sh = 0;
         endcase
      end
      return sh;
   endfunction

   // Search the prescalers in ascending order, ceiling count then floor count;
   // a count wins only on strictly smaller exact error.
   function automatic timer_setting_type pick_timer_setting(input logic [1:0] sel,
                                                            input logic [31:0] period);
      timer_setting_type res;
      logic [63:0]       d, size, p, c, per, err, best_err, win_count, cmp;
      int                n, i, j, sh, best_idx;
      bit                found;
      res       = REFUSED;
      d         = {32'd0, period};
      found     = 1'b0;
      best_err  = '0;
      win_count = '0;
      best_idx  = 0;
      n         = 0;
      size      = '0;
      case (sel)
         tpcs_pkg::TIMER_ONE: begin
            n    = 5;
            size = 64'd65536;
         end
         tpcs_pkg::TIMER_TWO: begin
            n    = 7;
            size = 64'd256;
         end
         default: return res;
      endcase
      if (d < {32'd0, tpcs_pkg::MIN_PERIOD})
         return res;
      for (i = 0; i < n; i++) begin
         sh = prescale_shift(sel, i);
         p  = 64'd1 << sh;
         for (j = 0; j < 2; j++) begin
            c   = (j == 0) ? ((d + p - 64'd1) >> sh) : (d >> sh);
            per = c << sh;
            err = (per >= d) ? (per - d) : (d - per);
            // zero floor count never qualifies
            if (c >= 64'd1 && c <= size && (!found || err < best_err)) begin
               found     = 1'b1;
               best_err  = err;
               win_count = c;
               best_idx  = i;
            end
         end
      end
      if (!found)
         return res;
      res.error_flag = 1'b0;
      res.control_b  = 8'(best_idx + 1);
      if (win_count == size) begin
         // full counter: normal mode
         cmp               = 64'd2 * (size - 64'd1) / 64'd3;
         res.handler_slots = tpcs_pkg::SLOTS_NORMAL;
      end else begin
         cmp               = win_count - 64'd1;
         res.handler_slots = tpcs_pkg::SLOTS_CTC;
         if (sel == tpcs_pkg::TIMER_ONE)
            res.control_b = res.control_b | tpcs_pkg::T1_CTC_B;
         else
            res.control_a = tpcs_pkg::T2_CTC_A;
      end
      res.match_a              = cmp[15:0];
      res.match_b              = cmp[15:0] >> 1;
      res.actual_period_cycles = 27'(win_count << prescale_shift(sel, best_idx));
      return res;
   endfunction

   function automatic timer_setting_type make_setting(input logic [7:0] ca,
                                                      input logic [7:0] cb,
                                                      input logic [15:0] cmpa,
                                                      input logic [15:0] cmpb,
                                                      input logic [1:0] slots,
                                                      input logic [26:0] per);
      timer_setting_type res;
      res = {1'b0, ca, cb, cmpa, cmpb, slots, per};
      return res;
   endfunction

   task automatic add_row(input logic [1:0] sel, input logic [31:0] period, input bit typed,
                          input timer_setting_type result);
      stim_row_type row;
      row.timer_select = sel;
      row.period       = period;
      row.typed        = typed;
      row.result       = result;
      directed_rows.push_back(row);
   endtask

   // Offer one request item; valid stays up across back-to-back items.
   task automatic offer_request(input logic [1:0] sel, input logic [31:0] period,
                                input timer_setting_type expected);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid                 <= 1'b1;
      req_chan.timer_select          <= sel;
      req_chan.desired_period_cycles <= period;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pending_settings.push_back(expected);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left       = HOLD_OFF_LEN;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      timer_setting_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.error_flag, rsp_chan.control_a, rsp_chan.control_b,
                rsp_chan.match_a, rsp_chan.match_b, rsp_chan.handler_slots,
                rsp_chan.actual_period_cycles};
         if (pending_settings.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("result %0d arrived with nothing expected: err=%0d ca=%h cb=%h",
                        result_count, got.error_flag, got.control_a, got.control_b);
            mismatch_count++;
         end else begin
            want = pending_settings.pop_front();
            if (got.error_flag !== want.error_flag || got.control_a !== want.control_a ||
                got.control_b !== want.control_b || got.match_a !== want.match_a ||
                got.match_b !== want.match_b ||
                got.handler_slots !== want.handler_slots ||
                got.actual_period_cycles !== want.actual_period_cycles) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("result %0d mismatch", result_count);
                  $display("  exp err=%0d ca=%h cb=%h cmpa=%0d cmpb=%0d slots=%0d per=%0d",
                           want.error_flag, want.control_a, want.control_b, want.match_a,
                           want.match_b, want.handler_slots, want.actual_period_cycles);
                  $display("  got err=%0d ca=%h cb=%h cmpa=%0d cmpb=%0d slots=%0d per=%0d",
                           got.error_flag, got.control_a, got.control_b, got.match_a,
                           got.match_b, got.handler_slots, got.actual_period_cycles);
               end
               mismatch_count++;
            end
         end
         result_count++;
      end
   end

   initial begin : stimulus
      timer_setting_type want;
      logic [1:0]        sel;
      logic [31:0]       period, top, base;
      int                roll, k, sh;

      reset                          <= 1'b1;
      req_chan.valid                 <= 1'b0;
      req_chan.timer_select          <= TIMER_NONE;
      req_chan.desired_period_cycles <= '0;

      // Directed table; hand-written results only for refusals and exact fits.
      add_row(TIMER_NONE, 32'd1000,       1'b1, REFUSED);
      add_row(TIMER_RSVD, 32'hFFFF_FFFF,  1'b1, REFUSED);
      add_row(TIMER_NONE, 32'd0,          1'b1, REFUSED);
      add_row(TIMER_RSVD, 32'd16,         1'b1, REFUSED);
      // below the minimum period
      add_row(tpcs_pkg::TIMER_ONE,  32'd0,          1'b1, REFUSED);
      add_row(tpcs_pkg::TIMER_ONE,  32'd15,         1'b1, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'd15,         1'b1, REFUSED);
      // shortest period, CTC at prescaler 1
      add_row(tpcs_pkg::TIMER_ONE,  32'd16,         1'b1,
              make_setting(8'h00, 8'h09, 16'd15, 16'd7, tpcs_pkg::SLOTS_CTC, 27'd16));
      add_row(tpcs_pkg::TIMER_TWO,  32'd16,         1'b1,
              make_setting(8'h02, 8'h01, 16'd15, 16'd7, tpcs_pkg::SLOTS_CTC, 27'd16));
      // full counter at prescaler 1: normal mode
      add_row(tpcs_pkg::TIMER_ONE,  32'd65536,      1'b1,
              make_setting(8'h00, 8'h01, 16'd43690, 16'd21845, tpcs_pkg::SLOTS_NORMAL,
                           27'd65536));
      add_row(tpcs_pkg::TIMER_TWO,  32'd256,        1'b1,
              make_setting(8'h00, 8'h01, 16'd170, 16'd85, tpcs_pkg::SLOTS_NORMAL, 27'd256));
      // full counter at the largest prescaler
      add_row(tpcs_pkg::TIMER_ONE,  32'd67108864,   1'b1,
              make_setting(8'h00, 8'h05, 16'd43690, 16'd21845, tpcs_pkg::SLOTS_NORMAL,
                           27'd67108864));
      add_row(tpcs_pkg::TIMER_TWO,  32'd262144,     1'b1,
              make_setting(8'h00, 8'h07, 16'd170, 16'd85, tpcs_pkg::SLOTS_NORMAL,
                           27'd262144));
      // nothing fits
      add_row(tpcs_pkg::TIMER_ONE,  32'd67109888,   1'b1, REFUSED);
      add_row(tpcs_pkg::TIMER_ONE,  32'hFFFF_FFFF,  1'b1, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'd263168,     1'b1, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'hFFFF_FFFF,  1'b1, REFUSED);
      // off-grid periods, predicted
      add_row(tpcs_pkg::TIMER_ONE,  32'd67108865,   1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_ONE,  32'd65537,      1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'd257,        1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_ONE,  32'd17,         1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'd255,        1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_ONE,  32'd1000003,    1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'd100000,     1'b0, REFUSED);
      add_row(tpcs_pkg::TIMER_TWO,  32'h5555_5555,  1'b0, REFUSED);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].typed ? directed_rows[i].result :
                pick_timer_setting(directed_rows[i].timer_select, directed_rows[i].period);
         offer_request(directed_rows[i].timer_select, directed_rows[i].period, want);
      end

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) begin
            req_idle_pct = 71;
            rsp_idle_pct = 10;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            // no idling; long result stall so the pipeline backs up
            req_idle_pct     = 0;
            rsp_idle_pct     = 0;
            hold_off_pending = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            sel    = 2'($urandom_range(0, 3));
            period = $urandom;
         end else if (roll < 14) begin
            sel    = 2'($urandom_range(0, 3));
            period = $urandom_range(0, 24);
         end else begin
            sel = ($urandom_range(0, 1) == 0) ? tpcs_pkg::TIMER_ONE : tpcs_pkg::TIMER_TWO;
            top = (sel == tpcs_pkg::TIMER_ONE) ? 32'd67108864 : 32'd262144;
            case ($urandom_range(0, 4))
               0: period = $urandom_range(16, 1100);
               1: period = $urandom_range(16, top + 4096);
               2: period = $urandom_range(16, top) >> $urandom_range(0, 16);
               3: begin
                  // around a full count at some prescaler
                  sh     = prescale_shift(sel, $urandom_range(0,
                                          (sel == tpcs_pkg::TIMER_ONE) ? 4 : 6));
                  base   = ((sel == tpcs_pkg::TIMER_ONE) ? 32'd65536 : 32'd256) << sh;
                  period = base + $urandom_range(0, 64) - 32'd32;
               end
               default: period = $urandom_range(top / 2, top + 1024);
            endcase
         end
         offer_request(sel, period, pick_timer_setting(sel, period));
      end
      req_chan.valid <= 1'b0;

      while (pending_settings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_settings.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule
